### src/mfsp_pkg.sv
// Shared types, codes and helper functions of the MIDI file stream parser.
`timescale 1ns / 1ps
`default_nettype none

package mfsp_pkg;

   typedef enum logic [11:0] {
      PH_HDR_TAG   = 12'b0000_0000_0001,
      PH_HDR_LEN   = 12'b0000_0000_0010,
      PH_HDR_BODY  = 12'b0000_0000_0100,
      PH_TRK_TAG   = 12'b0000_0000_1000,
      PH_TRK_LEN   = 12'b0000_0001_0000,
      PH_DELTA     = 12'b0000_0010_0000,
      PH_STATUS    = 12'b0000_0100_0000,
      PH_DATA1     = 12'b0000_1000_0000,
      PH_DATA2     = 12'b0001_0000_0000,
      PH_META_TYPE = 12'b0010_0000_0000,
      PH_EV_LEN    = 12'b0100_0000_0000,
      PH_PAYLOAD   = 12'b1000_0000_0000
   } phase_type;

   localparam logic [2:0] KIND_HEADER      = 3'd0;
   localparam logic [2:0] KIND_TRACK_START = 3'd1;
   localparam logic [2:0] KIND_SHORT       = 3'd2;
   localparam logic [2:0] KIND_SYSEX_START = 3'd3;
   localparam logic [2:0] KIND_META_START  = 3'd4;
   localparam logic [2:0] KIND_PAYLOAD     = 3'd5;
   localparam logic [2:0] KIND_ERROR       = 3'd6;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_MTHD    = 3'd1;
   localparam logic [2:0] ERR_HDR_LENGTH  = 3'd2;
   localparam logic [2:0] ERR_BAD_FORMAT  = 3'd3;
   localparam logic [2:0] ERR_BAD_MTRK    = 3'd4;

   localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_CONT = 8'hF7;
   localparam logic [7:0] STATUS_META       = 8'hFF;
   localparam logic [7:0] STATUS_RESET_RUN  = 8'h80;
   localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
   localparam logic [7:0] HDR_LENGTH        = 8'd6;
   localparam logic [7:0] MAX_FORMAT        = 8'd2;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [31:0] delta_ticks;
      logic [7:0]  status_byte;
      logic [7:0]  data_first;
      logic [7:0]  data_second;
      logic [7:0]  meta_kind;
      logic [31:0] payload_length;
      logic        last_of_payload;
      logic        uses_quarter_ticks;
      logic [14:0] ticks_per_unit;
      logic [6:0]  frames_per_second;
      logic [2:0]  error_code;
   } record_type;

   typedef struct packed {
      logic      error_latched;
      phase_type phase;
   } parse_status_type;

   // Expected bytes of the "MThd" tag.
   function automatic logic [7:0] hdr_tag_byte(input logic [1:0] idx);
      logic [7:0] tag;
      case (idx)
         2'd0: tag = 8'h4D;
         2'd1: tag = 8'h54;
         2'd2: tag = 8'h68;
         default: tag = 8'h64;
      endcase
      return tag;
   endfunction

   // Expected bytes of the "MTrk" tag.
   function automatic logic [7:0] trk_tag_byte(input logic [1:0] idx);
      logic [7:0] tag;
      case (idx)
         2'd0: tag = 8'h4D;
         2'd1: tag = 8'h54;
         2'd2: tag = 8'h72;
         default: tag = 8'h6B;
      endcase
      return tag;
   endfunction

   // Number of data bytes that follow a status byte.
   function automatic logic [1:0] data_count(input logic [7:0] status);
      logic [1:0] count;
      if (status[7:4] == 4'hC || status[7:4] == 4'hD) begin
         count = 2'd1;
      end else if (status[7:4] != 4'hF) begin
         count = 2'd2;
      end else if (status == 8'hF1 || status == 8'hF3) begin
         count = 2'd1;
      end else if (status == 8'hF2) begin
         count = 2'd2;
      end else begin
         count = 2'd0;
      end
      return count;
   endfunction

endpackage

`default_nettype wire

### src/midi_file_stream_parser_core.sv
// Top level of the MIDI file stream parser: input register, parser and result register.
// A byte accepted into the input register is parsed into the result register once that register can take it.
// Throughput: one byte per cycle while the result register is not stalled; the parse state machine sets this rate.
// Each byte yields zero or one record; the result register frees itself as it drains.
// Reset is synchronous and active high; it returns the parser to the file header tag.
// All state is in flip-flops, so the block is ready on the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module midi_file_stream_parser_core
   import mfsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_file_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_record_kind,
   output logic [31:0]      rsp_delta_ticks,
   output logic [7:0]       rsp_status_byte,
   output logic [7:0]       rsp_data_first,
   output logic [7:0]       rsp_data_second,
   output logic [7:0]       rsp_meta_kind,
   output logic [31:0]      rsp_payload_length,
   output logic             rsp_last_of_payload,
   output logic             rsp_uses_quarter_ticks,
   output logic [14:0]      rsp_ticks_per_unit,
   output logic [6:0]       rsp_frames_per_second,
   output logic [2:0]       rsp_error_code
);

   logic             byte_valid_ff;
   logic [7:0]       byte_ff;
   logic             rsp_valid_ff;
   record_type       rsp_rec_ff;
   logic             advance;
   logic             emit;
   record_type       record;
   parse_status_type status;

   // The held byte is parsed once the result register can take its record.
   assign advance   = byte_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = byte_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         byte_valid_ff <= 1'b1;
      end else if (advance) begin
         byte_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_file_byte;
      end
   end

   mfsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .file_byte (byte_ff),
      .emit      (emit),
      .record    (record),
      .status    (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_rec_ff <= record;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_record_kind        = rsp_rec_ff.record_kind;
   assign rsp_delta_ticks        = rsp_rec_ff.delta_ticks;
   assign rsp_status_byte        = rsp_rec_ff.status_byte;
   assign rsp_data_first         = rsp_rec_ff.data_first;
   assign rsp_data_second        = rsp_rec_ff.data_second;
   assign rsp_meta_kind          = rsp_rec_ff.meta_kind;
   assign rsp_payload_length     = rsp_rec_ff.payload_length;
   assign rsp_last_of_payload    = rsp_rec_ff.last_of_payload;
   assign rsp_uses_quarter_ticks = rsp_rec_ff.uses_quarter_ticks;
   assign rsp_ticks_per_unit     = rsp_rec_ff.ticks_per_unit;
   assign rsp_frames_per_second  = rsp_rec_ff.frames_per_second;
   assign rsp_error_code         = rsp_rec_ff.error_code;

   // Once an error is latched and its record has drained, no transaction follows.
   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      status.error_latched && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("record produced after a latched error");

   // An error code appears exactly on error records.
   a_error_code_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_rec_ff.record_kind == KIND_ERROR) ==
                        (rsp_rec_ff.error_code != ERR_NONE)))
      else $error("error code does not match record kind");

   // The last-of-payload flag is only set on payload byte records.
   a_last_on_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rec_ff.last_of_payload |->
         rsp_rec_ff.record_kind == KIND_PAYLOAD)
      else $error("last_of_payload set on a non-payload record");

   // A new error record always leaves the parser in the latched error condition.
   a_error_latches: assert property (@(posedge clock) disable iff (reset)
      advance && emit && record.record_kind == KIND_ERROR |=> status.error_latched)
      else $error("error record without latched error");

endmodule

`default_nettype wire

### src/mfsp_parser.sv
// Byte-level parse state machine that turns one file byte into at most one record.
`timescale 1ns / 1ps
`default_nettype none

module mfsp_parser
   import mfsp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       file_byte,
   output logic                  emit,
   output record_type            record,
   output parse_status_type      status
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] delta_ff, delta_in;
   logic [7:0]  running_ff, running_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic [7:0]  meta_ff, meta_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  format_ff, format_in;
   logic [15:0] tracks_ff, tracks_in;
   logic        error_ff, error_in;
   logic [7:0]  cur_status_ff, cur_status_in;

   logic [31:0] acc_byte;
   logic [31:0] acc_vlq;
   logic [15:0] division;
   logic [31:0] remain_dec;
   logic        end_of_track;
   logic [2:0]  count_inc;

   assign acc_byte     = {acc_ff[23:0], file_byte};
   assign acc_vlq      = {acc_ff[24:0], file_byte[6:0]};
   assign division     = {acc_ff[7:0], file_byte};
   assign remain_dec   = remain_ff - 32'd1;
   assign end_of_track = (held_data_ff == STATUS_META) && (meta_ff == META_END_OF_TRACK);
   assign count_inc    = count_ff + 3'd1;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      delta_in      = delta_ff;
      running_in    = running_ff;
      held_data_in  = held_data_ff;
      meta_in       = meta_ff;
      remain_in     = remain_ff;
      format_in     = format_ff;
      tracks_in     = tracks_ff;
      error_in      = error_ff;
      cur_status_in = cur_status_ff;
      emit          = 1'b0;
      record        = '0;

      if (!error_ff) begin
         case (phase_ff)
            PH_HDR_TAG: begin
               if (file_byte != hdr_tag_byte(count_ff[1:0])) begin
                  error_in           = 1'b1;
                  emit               = 1'b1;
                  record.record_kind = KIND_ERROR;
                  record.error_code  = ERR_BAD_MTHD;
               end else if (count_ff == 3'd3) begin
                  count_in = '0;
                  acc_in   = '0;
                  phase_in = PH_HDR_LEN;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_HDR_LEN: begin
               acc_in   = acc_byte;
               count_in = count_inc;
               if (count_ff == 3'd3) begin
                  if (acc_byte != {24'd0, HDR_LENGTH}) begin
                     error_in           = 1'b1;
                     emit               = 1'b1;
                     record.record_kind = KIND_ERROR;
                     record.error_code  = ERR_HDR_LENGTH;
                  end else begin
                     count_in = '0;
                     acc_in   = '0;
                     phase_in = PH_HDR_BODY;
                  end
               end
            end
            PH_HDR_BODY: begin
               count_in = count_inc;
               case (count_ff)
                  3'd0: format_in = file_byte;
                  3'd1: begin
                     format_in = file_byte;
                     if (format_ff != 8'd0 || file_byte > MAX_FORMAT) begin
                        error_in           = 1'b1;
                        emit               = 1'b1;
                        record.record_kind = KIND_ERROR;
                        record.error_code  = ERR_BAD_FORMAT;
                     end
                  end
                  3'd2, 3'd3: tracks_in = {tracks_ff[7:0], file_byte};
                  default: acc_in = {16'd0, division};
               endcase
               if (count_ff == 3'd5) begin
                  emit                  = 1'b1;
                  record.record_kind    = KIND_HEADER;
                  record.data_first     = format_ff;
                  record.payload_length = {16'd0, tracks_ff};
                  if (!division[15]) begin
                     record.uses_quarter_ticks = 1'b1;
                     record.ticks_per_unit     = division[14:0];
                  end else begin
                     record.ticks_per_unit    = {7'd0, division[7:0]};
                     record.frames_per_second = division[14:8];
                  end
                  count_in = '0;
                  acc_in   = '0;
                  phase_in = PH_TRK_TAG;
               end
            end
            PH_TRK_TAG: begin
               if (file_byte != trk_tag_byte(count_ff[1:0])) begin
                  error_in           = 1'b1;
                  emit               = 1'b1;
                  record.record_kind = KIND_ERROR;
                  record.error_code  = ERR_BAD_MTRK;
               end else if (count_ff == 3'd3) begin
                  count_in = '0;
                  acc_in   = '0;
                  phase_in = PH_TRK_LEN;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_TRK_LEN: begin
               acc_in   = acc_byte;
               count_in = count_inc;
               if (count_ff == 3'd3) begin
                  emit                  = 1'b1;
                  record.record_kind    = KIND_TRACK_START;
                  record.payload_length = acc_byte;
                  count_in              = '0;
                  acc_in                = '0;
                  phase_in              = (acc_byte == 32'd0) ? PH_TRK_TAG : PH_DELTA;
               end
            end
            PH_DELTA: begin
               acc_in = acc_vlq;
               if (!file_byte[7]) begin
                  delta_in = acc_vlq;
                  acc_in   = '0;
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (file_byte == STATUS_SYSEX || file_byte == STATUS_SYSEX_CONT) begin
                  held_data_in = file_byte;
                  meta_in      = '0;
                  acc_in       = '0;
                  phase_in     = PH_EV_LEN;
               end else if (file_byte == STATUS_META) begin
                  held_data_in = file_byte;
                  phase_in     = PH_META_TYPE;
               end else if (file_byte[7]) begin
                  cur_status_in = file_byte;
                  if (file_byte < STATUS_SYSEX) begin
                     running_in = file_byte;
                  end
                  if (data_count(file_byte) == 2'd0) begin
                     emit               = 1'b1;
                     record.record_kind = KIND_SHORT;
                     record.delta_ticks = delta_ff;
                     record.status_byte = file_byte;
                     phase_in           = PH_DELTA;
                     acc_in             = '0;
                  end else begin
                     phase_in = PH_DATA1;
                  end
               end else begin
                  cur_status_in = running_ff;
                  held_data_in  = file_byte;
                  if (data_count(running_ff) == 2'd1) begin
                     emit               = 1'b1;
                     record.record_kind = KIND_SHORT;
                     record.delta_ticks = delta_ff;
                     record.status_byte = running_ff;
                     record.data_first  = file_byte;
                     phase_in           = PH_DELTA;
                     acc_in             = '0;
                  end else begin
                     phase_in = PH_DATA2;
                  end
               end
            end
            PH_DATA1: begin
               held_data_in = file_byte;
               if (data_count(cur_status_ff) == 2'd1) begin
                  emit               = 1'b1;
                  record.record_kind = KIND_SHORT;
                  record.delta_ticks = delta_ff;
                  record.status_byte = cur_status_ff;
                  record.data_first  = file_byte;
                  phase_in           = PH_DELTA;
                  acc_in             = '0;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               emit               = 1'b1;
               record.record_kind = KIND_SHORT;
               record.delta_ticks = delta_ff;
               record.status_byte = cur_status_ff;
               record.data_first  = held_data_ff;
               record.data_second = file_byte;
               phase_in           = PH_DELTA;
               acc_in             = '0;
            end
            PH_META_TYPE: begin
               meta_in  = file_byte;
               acc_in   = '0;
               phase_in = PH_EV_LEN;
            end
            PH_EV_LEN: begin
               acc_in = acc_vlq;
               if (!file_byte[7]) begin
                  emit                  = 1'b1;
                  record.record_kind    = (held_data_ff == STATUS_META) ?
                                          KIND_META_START : KIND_SYSEX_START;
                  record.delta_ticks    = delta_ff;
                  record.status_byte    = held_data_ff;
                  record.meta_kind      = meta_ff;
                  record.payload_length = acc_vlq;
                  remain_in             = acc_vlq;
                  if (acc_vlq == 32'd0) begin
                     acc_in = '0;
                     if (end_of_track) begin
                        phase_in = PH_TRK_TAG;
                        count_in = '0;
                     end else begin
                        phase_in = PH_DELTA;
                     end
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               emit               = 1'b1;
               record.record_kind = KIND_PAYLOAD;
               record.delta_ticks = delta_ff;
               record.status_byte = held_data_ff;
               record.data_first  = file_byte;
               record.meta_kind   = meta_ff;
               remain_in          = remain_dec;
               if (remain_dec == 32'd0) begin
                  record.last_of_payload = 1'b1;
                  acc_in                 = '0;
                  if (end_of_track) begin
                     phase_in = PH_TRK_TAG;
                     count_in = '0;
                  end else begin
                     phase_in = PH_DELTA;
                  end
               end
            end
            default: begin
               phase_in = PH_HDR_TAG;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR_TAG;
         count_ff      <= '0;
         acc_ff        <= '0;
         delta_ff      <= '0;
         running_ff    <= STATUS_RESET_RUN;
         held_data_ff  <= '0;
         meta_ff       <= '0;
         remain_ff     <= '0;
         format_ff     <= '0;
         tracks_ff     <= '0;
         error_ff      <= 1'b0;
         cur_status_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         acc_ff        <= acc_in;
         delta_ff      <= delta_in;
         running_ff    <= running_in;
         held_data_ff  <= held_data_in;
         meta_ff       <= meta_in;
         remain_ff     <= remain_in;
         format_ff     <= format_in;
         tracks_ff     <= tracks_in;
         error_ff      <= error_in;
         cur_status_ff <= cur_status_in;
      end
   end

   assign status.error_latched = error_ff;
   assign status.phase         = phase_ff;

endmodule

`default_nettype wire
